// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define VSAR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vsar assertion failed");

// clocked check that also holds through reset
`define VSAR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vsar assertion failed");

`endif

// ----- hw/rtl/vsar_pkg.sv -----
`default_nettype none

package vsar_pkg;

    // item kinds
    localparam logic [2:0] KIND_READ        = 3'd0;
    localparam logic [2:0] KIND_WRITE       = 3'd1;
    localparam logic [2:0] KIND_INC_X       = 3'd2;
    localparam logic [2:0] KIND_INC_Y       = 3'd3;
    localparam logic [2:0] KIND_COPY_X      = 3'd4;
    localparam logic [2:0] KIND_COPY_Y      = 3'd5;
    localparam logic [2:0] KIND_VBLANK_BEG  = 3'd6;
    localparam logic [2:0] KIND_VBLANK_END  = 3'd7;

    // register numbers
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // pointer fields and limits
    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] COPY_X_MASK  = 16'h041F;
    localparam logic [15:0] COPY_Y_MASK  = 16'h7BE0;
    localparam logic [15:0] NT_X_BIT     = 16'h0400;
    localparam logic [15:0] NT_Y_BIT     = 16'h0800;
    localparam logic [15:0] FINE_Y_ONE   = 16'h1000;
    localparam logic [4:0]  COARSE_MAX   = 5'd31;
    localparam logic [4:0]  COARSE_Y_END = 5'd29;
    localparam logic [2:0]  FINE_Y_MAX   = 3'd7;
    localparam logic [15:0] STEP_ROW     = 16'd32;
    localparam logic [15:0] STEP_ONE     = 16'd1;

    typedef struct packed {
        logic [15:0] active_pointer;
        logic [15:0] temp_pointer;
        logic [2:0]  fine_x;
        logic        write_toggle;
        logic [7:0]  read_buffer;
        logic [7:0]  control_byte;
        logic [7:0]  mask_byte;
        logic        vblank_flag;
    } t_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] mem_data;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        mem_write;
        logic        mem_read;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
        logic        nmi_pulse;
        logic [15:0] pointer_now;
        logic [2:0]  fine_scroll_x;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/vsar_in_if.sv -----
`default_nettype none

// request channel: one event per item
interface vsar_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] mem_data;

    modport source (output valid, output kind, output reg_index, output write_data,
                    output mem_data, input ready);
    modport sink   (input valid, input kind, input reg_index, input write_data,
                    input mem_data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vsar_out_if.sv -----
`default_nettype none

// result channel: one result per item
interface vsar_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        mem_write;
    logic        mem_read;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic        nmi_pulse;
    logic [15:0] pointer_now;
    logic [2:0]  fine_scroll_x;

    modport source (output valid, output read_data, output mem_write, output mem_read,
                    output mem_address, output mem_write_data, output nmi_pulse,
                    output pointer_now, output fine_scroll_x, input ready);
    modport sink   (input valid, input read_data, input mem_write, input mem_read,
                    input mem_address, input mem_write_data, input nmi_pulse,
                    input pointer_now, input fine_scroll_x, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/video_scroll_address_registers.sv -----
// Scroll and address register unit of a tile video processor. Each request item is one
// event (CPU register read or write, horizontal or vertical scroll step, horizontal or
// vertical copy from the temporary pointer, vblank begin or end) and yields exactly one
// result item, in order. An item is accepted in every cycle while the result register
// is empty or being drained; its result is registered and appears in the cycle after
// acceptance. The state update is a single pass of shallow logic, so throughput is one
// item per clock while results drain. The data-port byte for a read must be presented
// with the read request on mem_data; reads at or above 0x3F00 return that byte directly.
`default_nettype none
`include "assert_macros.svh"

module video_scroll_address_registers (
    input  wire          i_clk,
    input  wire          i_rst_n,
    vsar_in_if.sink      i_item,
    vsar_out_if.source   o_result
);

    vsar_pkg::t_state  r_state;
    vsar_pkg::t_state  n_state;
    vsar_pkg::t_result r_res;
    vsar_pkg::t_result n_res;
    vsar_pkg::t_item   w_item;
    logic              r_valid;
    logic              w_accept;
    logic              w_data_acc;
    logic [15:0]       w_step;
    logic [15:0]       w_ptr_step;

    // accept whenever the result slot is free or drains this cycle
    assign i_item.ready = !r_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_item.kind       = i_item.kind;
    assign w_item.reg_index  = i_item.reg_index;
    assign w_item.write_data = i_item.write_data;
    assign w_item.mem_data   = i_item.mem_data;

    // event logic
    vsar_step u_step (
        .i_state  (r_state),
        .i_item   (w_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.read_data      = r_res.read_data;
    assign o_result.mem_write      = r_res.mem_write;
    assign o_result.mem_read       = r_res.mem_read;
    assign o_result.mem_address    = r_res.mem_address;
    assign o_result.mem_write_data = r_res.mem_write_data;
    assign o_result.nmi_pulse      = r_res.nmi_pulse;
    assign o_result.pointer_now    = r_res.pointer_now;
    assign o_result.fine_scroll_x  = r_res.fine_scroll_x;

    // data-port access seen at the input
    assign w_data_acc = w_accept && (i_item.reg_index == vsar_pkg::REG_DATA)
                     && ((i_item.kind == vsar_pkg::KIND_READ)
                      || (i_item.kind == vsar_pkg::KIND_WRITE));
    assign w_step     = r_state.control_byte[2] ? vsar_pkg::STEP_ROW : vsar_pkg::STEP_ONE;
    assign w_ptr_step = r_state.active_pointer + w_step;

    // checks
    `VSAR_ASSERT(a_mem_excl, i_clk, i_rst_n, r_valid |-> !(r_res.mem_read && r_res.mem_write))
    `VSAR_ASSERT(a_data_advance, i_clk, i_rst_n, w_data_acc |=> (r_state.active_pointer == $past(w_ptr_step)))
    `VSAR_ASSERT(a_nmi_flag, i_clk, i_rst_n, (r_valid && r_res.nmi_pulse) |-> r_state.vblank_flag)
    `VSAR_ASSERT(a_ptr_view, i_clk, i_rst_n, r_valid |-> (r_res.pointer_now == r_state.active_pointer))
    `VSAR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/vsar_step.sv -----
`default_nettype none

// next state and result of one event
module vsar_step (
    input  wire vsar_pkg::t_state  i_state,
    input  wire vsar_pkg::t_item   i_item,
    output vsar_pkg::t_state  o_state,
    output vsar_pkg::t_result o_result
);

    logic        render_on;
    logic [15:0] ptr;
    logic [15:0] data_step;
    logic [15:0] ptr_inc_x;
    logic [15:0] ptr_inc_y;
    logic [15:0] ptr_y_clr;
    logic [4:0]  tile_row;

    assign ptr       = i_state.active_pointer;
    assign render_on = i_state.mask_byte[4] | i_state.mask_byte[3];
    assign data_step = i_state.control_byte[2] ? vsar_pkg::STEP_ROW : vsar_pkg::STEP_ONE;

    // horizontal step with nametable flip at the row end
    always_comb begin
        if (ptr[4:0] == vsar_pkg::COARSE_MAX) begin
            ptr_inc_x = {ptr[15:5], 5'd0} ^ vsar_pkg::NT_X_BIT;
        end else begin
            ptr_inc_x = ptr + vsar_pkg::STEP_ONE;
        end
    end

    // vertical step: fine y first, then coarse y with the wrap at 29
    always_comb begin
        ptr_y_clr = {ptr[15], 3'd0, ptr[11:0]};
        tile_row  = ptr[9:5];
        ptr_inc_y = ptr_y_clr;
        if (ptr[14:12] != vsar_pkg::FINE_Y_MAX) begin
            ptr_inc_y = ptr + vsar_pkg::FINE_Y_ONE;
        end else if (tile_row == vsar_pkg::COARSE_Y_END) begin
            ptr_inc_y = (ptr_y_clr ^ vsar_pkg::NT_Y_BIT) & ~16'h03E0;
        end else if (tile_row == vsar_pkg::COARSE_MAX) begin
            ptr_inc_y = ptr_y_clr & ~16'h03E0;
        end else begin
            ptr_inc_y = {ptr_y_clr[15:10], tile_row + 5'd1, ptr_y_clr[4:0]};
        end
    end

    // event decode
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.kind)
            vsar_pkg::KIND_READ: begin
                case (i_item.reg_index)
                    vsar_pkg::REG_STATUS: begin
                        o_result.read_data   = {i_state.vblank_flag, 2'b00,
                                                i_state.read_buffer[4:0]};
                        o_state.vblank_flag  = 1'b0;
                        o_state.write_toggle = 1'b0;
                    end
                    vsar_pkg::REG_DATA: begin
                        o_result.read_data = (ptr >= vsar_pkg::PALETTE_BASE) ?
                                             i_item.mem_data : i_state.read_buffer;
                        o_state.read_buffer    = i_item.mem_data;
                        o_result.mem_read      = 1'b1;
                        o_result.mem_address   = ptr;
                        o_state.active_pointer = ptr + data_step;
                    end
                    default: begin
                    end
                endcase
            end
            vsar_pkg::KIND_WRITE: begin
                case (i_item.reg_index)
                    vsar_pkg::REG_CONTROL: begin
                        o_state.control_byte       = i_item.write_data;
                        o_state.temp_pointer[11:10] = i_item.write_data[1:0];
                    end
                    vsar_pkg::REG_MASK: begin
                        o_state.mask_byte = i_item.write_data;
                    end
                    vsar_pkg::REG_SCROLL: begin
                        if (!i_state.write_toggle) begin
                            o_state.fine_x            = i_item.write_data[2:0];
                            o_state.temp_pointer[4:0] = i_item.write_data[7:3];
                            o_state.write_toggle      = 1'b1;
                        end else begin
                            o_state.temp_pointer[14:12] = i_item.write_data[2:0];
                            o_state.temp_pointer[9:5]   = i_item.write_data[7:3];
                            o_state.write_toggle        = 1'b0;
                        end
                    end
                    vsar_pkg::REG_ADDRESS: begin
                        if (!i_state.write_toggle) begin
                            o_state.temp_pointer = {2'b00, i_item.write_data[5:0],
                                                    i_state.temp_pointer[7:0]};
                            o_state.write_toggle = 1'b1;
                        end else begin
                            o_state.temp_pointer   = {i_state.temp_pointer[15:8],
                                                      i_item.write_data};
                            o_state.active_pointer = {i_state.temp_pointer[15:8],
                                                      i_item.write_data};
                            o_state.write_toggle   = 1'b0;
                        end
                    end
                    vsar_pkg::REG_DATA: begin
                        o_result.mem_write      = 1'b1;
                        o_result.mem_address    = ptr;
                        o_result.mem_write_data = i_item.write_data;
                        o_state.active_pointer  = ptr + data_step;
                    end
                    default: begin
                    end
                endcase
            end
            vsar_pkg::KIND_INC_X: begin
                if (render_on) begin
                    o_state.active_pointer = ptr_inc_x;
                end
            end
            vsar_pkg::KIND_INC_Y: begin
                if (render_on) begin
                    o_state.active_pointer = ptr_inc_y;
                end
            end
            vsar_pkg::KIND_COPY_X: begin
                if (render_on) begin
                    o_state.active_pointer = (ptr & ~vsar_pkg::COPY_X_MASK)
                                           | (i_state.temp_pointer & vsar_pkg::COPY_X_MASK);
                end
            end
            vsar_pkg::KIND_COPY_Y: begin
                if (render_on) begin
                    o_state.active_pointer = (ptr & ~vsar_pkg::COPY_Y_MASK)
                                           | (i_state.temp_pointer & vsar_pkg::COPY_Y_MASK);
                end
            end
            vsar_pkg::KIND_VBLANK_BEG: begin
                o_state.vblank_flag = 1'b1;
                o_result.nmi_pulse  = i_state.control_byte[7];
            end
            default: begin
                o_state.vblank_flag = 1'b0;
            end
        endcase
        o_result.pointer_now   = o_state.active_pointer;
        o_result.fine_scroll_x = o_state.fine_x;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_TAIL = 100;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        vsar_pkg::t_item ev;
        bit              wait_drain;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vsar_in_if  item_if ();
    vsar_out_if result_if ();

    video_scroll_address_registers dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // register file shadow and bookkeeping
    vsar_pkg::t_state  shadow;
    vsar_pkg::t_item   on_offer;
    t_pending          head_item;
    t_pending          pending_items[$];
    vsar_pkg::t_result due_results[$];
    int       items_sent = 0;
    int       results_checked = 0;
    int       mismatches = 0;
    int       cycle_count = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    bit       hold_active = 1'b0;
    bit       calm_phase = 1'b0;
    int       data_reads = 0;
    int       data_writes = 0;
    int       row_wraps = 0;
    int       nmi_count = 0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one event to the shadow registers and return its result
    function automatic vsar_pkg::t_result apply_event(vsar_pkg::t_item it);
        vsar_pkg::t_result r;
        logic [15:0]       ptr_step;
        logic [4:0]        cy;
        bit                render;
        r = '0;
        ptr_step = shadow.control_byte[2] ? vsar_pkg::STEP_ROW : vsar_pkg::STEP_ONE;
        render = shadow.mask_byte[3] | shadow.mask_byte[4];
        case (it.kind)
            vsar_pkg::KIND_READ: begin
                if (it.reg_index == vsar_pkg::REG_STATUS) begin
                    r.read_data = {shadow.vblank_flag, 2'b00, shadow.read_buffer[4:0]};
                    shadow.vblank_flag = 1'b0;
                    shadow.write_toggle = 1'b0;
                end else if (it.reg_index == vsar_pkg::REG_DATA) begin
                    // buffered read, palette range bypasses the buffer
                    r.read_data = (shadow.active_pointer >= vsar_pkg::PALETTE_BASE) ?
                                  it.mem_data : shadow.read_buffer;
                    shadow.read_buffer = it.mem_data;
                    r.mem_read = 1'b1;
                    r.mem_address = shadow.active_pointer;
                    shadow.active_pointer = shadow.active_pointer + ptr_step;
                    data_reads++;
                end
            end
            vsar_pkg::KIND_WRITE: begin
                case (it.reg_index)
                    vsar_pkg::REG_CONTROL: begin
                        shadow.control_byte = it.write_data;
                        shadow.temp_pointer[11:10] = it.write_data[1:0];
                    end
                    vsar_pkg::REG_MASK: shadow.mask_byte = it.write_data;
                    vsar_pkg::REG_SCROLL: begin
                        if (!shadow.write_toggle) begin
                            shadow.fine_x = it.write_data[2:0];
                            shadow.temp_pointer[4:0] = it.write_data[7:3];
                        end else begin
                            shadow.temp_pointer[14:12] = it.write_data[2:0];
                            shadow.temp_pointer[9:5] = it.write_data[7:3];
                        end
                        shadow.write_toggle = ~shadow.write_toggle;
                    end
                    vsar_pkg::REG_ADDRESS: begin
                        if (!shadow.write_toggle) begin
                            shadow.temp_pointer[15:8] = {2'b00, it.write_data[5:0]};
                        end else begin
                            shadow.temp_pointer[7:0] = it.write_data;
                            shadow.active_pointer = shadow.temp_pointer;
                        end
                        shadow.write_toggle = ~shadow.write_toggle;
                    end
                    vsar_pkg::REG_DATA: begin
                        r.mem_write = 1'b1;
                        r.mem_address = shadow.active_pointer;
                        r.mem_write_data = it.write_data;
                        shadow.active_pointer = shadow.active_pointer + ptr_step;
                        data_writes++;
                    end
                    default: ;
                endcase
            end
            vsar_pkg::KIND_INC_X: begin
                if (render) begin
                    if (shadow.active_pointer[4:0] == vsar_pkg::COARSE_MAX) begin
                        shadow.active_pointer[4:0] = 5'd0;
                        shadow.active_pointer = shadow.active_pointer ^ vsar_pkg::NT_X_BIT;
                    end else begin
                        shadow.active_pointer = shadow.active_pointer + vsar_pkg::STEP_ONE;
                    end
                end
            end
            vsar_pkg::KIND_INC_Y: begin
                if (render) begin
                    if (shadow.active_pointer[14:12] != vsar_pkg::FINE_Y_MAX) begin
                        shadow.active_pointer = shadow.active_pointer + vsar_pkg::FINE_Y_ONE;
                    end else begin
                        // fine y rolls over into coarse y
                        shadow.active_pointer[14:12] = 3'd0;
                        cy = shadow.active_pointer[9:5];
                        if (cy == vsar_pkg::COARSE_Y_END) begin
                            cy = 5'd0;
                            shadow.active_pointer = shadow.active_pointer ^ vsar_pkg::NT_Y_BIT;
                            row_wraps++;
                        end else if (cy == vsar_pkg::COARSE_MAX) begin
                            cy = 5'd0;
                        end else begin
                            cy = cy + 5'd1;
                        end
                        shadow.active_pointer[9:5] = cy;
                    end
                end
            end
            vsar_pkg::KIND_COPY_X: begin
                if (render)
                    shadow.active_pointer = (shadow.active_pointer & ~vsar_pkg::COPY_X_MASK)
                                          | (shadow.temp_pointer & vsar_pkg::COPY_X_MASK);
            end
            vsar_pkg::KIND_COPY_Y: begin
                if (render)
                    shadow.active_pointer = (shadow.active_pointer & ~vsar_pkg::COPY_Y_MASK)
                                          | (shadow.temp_pointer & vsar_pkg::COPY_Y_MASK);
            end
            vsar_pkg::KIND_VBLANK_BEG: begin
                shadow.vblank_flag = 1'b1;
                r.nmi_pulse = shadow.control_byte[7];
                if (r.nmi_pulse) nmi_count++;
            end
            default: shadow.vblank_flag = 1'b0;
        endcase
        r.pointer_now = shadow.active_pointer;
        r.fine_scroll_x = shadow.fine_x;
        return r;
    endfunction

    task automatic push_event(logic [2:0] k, logic [2:0] r, logic [7:0] wd, logic [7:0] md);
        t_pending p;
        p.ev = {k, r, wd, md};
        p.wait_drain = 1'b0;
        pending_items.push_back(p);
    endtask

    task automatic compare_field(string label, logic [15:0] want, logic [15:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         label, results_checked, want, seen);
        end
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            calm_phase = (pending_items.size() < CALM_TAIL);
            if (item_if.valid && item_if.ready) begin
                due_results.push_back(apply_event(on_offer));
                items_sent++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    item_if.valid <= 1'b0;
                end else if (pending_items[0].wait_drain && due_results.size() != 0) begin
                    item_if.valid <= 1'b0;
                end else if (!calm_phase && !hold_active && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    item_if.valid <= 1'b0;
                end else begin
                    head_item = pending_items.pop_front();
                    on_offer = head_item.ev;
                    item_if.kind <= on_offer.kind;
                    item_if.reg_index <= on_offer.reg_index;
                    item_if.write_data <= on_offer.write_data;
                    item_if.mem_data <= on_offer.mem_data;
                    item_if.valid <= 1'b1;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        vsar_pkg::t_result seen;
        vsar_pkg::t_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                seen = {result_if.read_data, result_if.mem_write, result_if.mem_read,
                        result_if.mem_address, result_if.mem_write_data,
                        result_if.nmi_pulse, result_if.pointer_now, result_if.fine_scroll_x};
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing pending: %h", seen);
                end else begin
                    want = due_results.pop_front();
                    compare_field("read_data", 16'(want.read_data), 16'(seen.read_data));
                    compare_field("mem_write", 16'(want.mem_write), 16'(seen.mem_write));
                    compare_field("mem_read", 16'(want.mem_read), 16'(seen.mem_read));
                    compare_field("mem_address", want.mem_address, seen.mem_address);
                    compare_field("mem_write_data", 16'(want.mem_write_data),
                                  16'(seen.mem_write_data));
                    compare_field("nmi_pulse", 16'(want.nmi_pulse), 16'(seen.nmi_pulse));
                    compare_field("pointer_now", want.pointer_now, seen.pointer_now);
                    compare_field("fine_scroll_x", 16'(want.fine_scroll_x),
                                  16'(seen.fine_scroll_x));
                    results_checked++;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0) hold_active = 1'b0;
                result_if.ready <= 1'b0;
            end else if (!hold_done && items_sent >= HOLD_AT) begin
                // long hold so the block backs up onto its input
                hold_done = 1'b1;
                hold_active = 1'b1;
                hold_left = HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached, %0d results outstanding",
                     CYCLE_LIMIT, due_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int         choice;
        int         n;
        logic [7:0] b;
        item_if.valid = 1'b0;
        item_if.kind = vsar_pkg::KIND_READ;
        item_if.reg_index = vsar_pkg::REG_STATUS;
        item_if.write_data = 8'h00;
        item_if.mem_data = 8'h00;
        result_if.ready = 1'b0;
        shadow = '0;

        // directed: vblank and nmi, rendering off, scroll and copies, palette reads
        push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_STATUS, 8'h00, 8'hFF);
        push_event(vsar_pkg::KIND_VBLANK_BEG, vsar_pkg::REG_DATA, 8'hFF, 8'hFF);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_CONTROL, 8'hFF, 8'h00);
        push_event(vsar_pkg::KIND_VBLANK_BEG, vsar_pkg::REG_CONTROL, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_STATUS, 8'hFF, 8'h00);
        push_event(vsar_pkg::KIND_VBLANK_END, vsar_pkg::REG_STATUS, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_MASK, 8'h00, 8'hFF);
        push_event(vsar_pkg::KIND_INC_X, vsar_pkg::REG_MASK, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_SCROLL, 8'hFF, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_SCROLL, 8'hFF, 8'h00);
        push_event(vsar_pkg::KIND_COPY_Y, vsar_pkg::REG_SCROLL, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_MASK, 8'h18, 8'h00);
        push_event(vsar_pkg::KIND_COPY_X, vsar_pkg::REG_CONTROL, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_COPY_Y, vsar_pkg::REG_CONTROL, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_CONTROL, 8'h03, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_DATA, 8'hA5, 8'h00);
        push_event(vsar_pkg::KIND_INC_X, vsar_pkg::REG_DATA, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_INC_Y, vsar_pkg::REG_DATA, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_COPY_X, vsar_pkg::REG_DATA, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_COPY_Y, vsar_pkg::REG_DATA, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_DATA, 8'h5A, 8'hFF);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_ADDRESS, 8'hFF, 8'h00);
        push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_ADDRESS, 8'h00, 8'h00);
        push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_DATA, 8'h00, 8'h5A);
        push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_DATA, 8'hFF, 8'h00);

        // random: mostly well-formed register sequences, some noise and lone writes
        while (pending_items.size() < 25 + RANDOM_ITEMS) begin
            choice = $urandom_range(0, 9);
            case (choice)
                0, 1: begin
                    push_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                               8'($urandom), 8'($urandom));
                end
                2, 3: begin
                    // scroll pair biased toward the bottom rows, then copies
                    push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_STATUS,
                               8'($urandom), 8'($urandom));
                    push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_SCROLL,
                               8'($urandom), 8'($urandom));
                    b = 8'($urandom);
                    if ($urandom_range(0, 1)) b[7:3] = 5'($urandom_range(27, 31));
                    if ($urandom_range(0, 1)) b[2:0] = 3'($urandom_range(6, 7));
                    push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_SCROLL, b, 8'($urandom));
                    push_event(vsar_pkg::KIND_COPY_X, 3'($urandom), 8'($urandom), 8'($urandom));
                    push_event(vsar_pkg::KIND_COPY_Y, 3'($urandom), 8'($urandom), 8'($urandom));
                end
                4, 5: begin
                    // scanline: horizontal steps, one vertical step, horizontal reload
                    b = 8'($urandom);
                    if ($urandom_range(0, 3) != 0) b[3] = 1'b1;
                    push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_MASK, b, 8'($urandom));
                    n = $urandom_range(1, 12);
                    repeat (n)
                        push_event(vsar_pkg::KIND_INC_X, 3'($urandom), 8'($urandom),
                                   8'($urandom));
                    push_event(vsar_pkg::KIND_INC_Y, 3'($urandom), 8'($urandom), 8'($urandom));
                    push_event(vsar_pkg::KIND_COPY_X, 3'($urandom), 8'($urandom), 8'($urandom));
                end
                6, 7: begin
                    // address pair then a burst of data-port accesses
                    push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_STATUS,
                               8'($urandom), 8'($urandom));
                    b = 8'($urandom);
                    if ($urandom_range(0, 2) == 0) b[5:0] = 6'h3F;
                    push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_ADDRESS, b, 8'($urandom));
                    push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_ADDRESS,
                               8'($urandom), 8'($urandom));
                    n = $urandom_range(1, 6);
                    repeat (n)
                        push_event($urandom_range(0, 1) ? vsar_pkg::KIND_READ
                                                        : vsar_pkg::KIND_WRITE,
                                   vsar_pkg::REG_DATA, 8'($urandom), 8'($urandom));
                end
                8: begin
                    push_event(vsar_pkg::KIND_WRITE, vsar_pkg::REG_CONTROL,
                               8'($urandom), 8'($urandom));
                    push_event(vsar_pkg::KIND_VBLANK_BEG, 3'($urandom), 8'($urandom),
                               8'($urandom));
                    if ($urandom_range(0, 1))
                        push_event(vsar_pkg::KIND_READ, vsar_pkg::REG_STATUS,
                                   8'($urandom), 8'($urandom));
                    push_event(vsar_pkg::KIND_VBLANK_END, 3'($urandom), 8'($urandom),
                               8'($urandom));
                end
                default: begin
                    // lone half of a pair, then vertical steps
                    push_event(vsar_pkg::KIND_WRITE,
                               $urandom_range(0, 1) ? vsar_pkg::REG_SCROLL
                                                    : vsar_pkg::REG_ADDRESS,
                               8'($urandom), 8'($urandom));
                    n = $urandom_range(1, 10);
                    repeat (n)
                        push_event(vsar_pkg::KIND_INC_Y, 3'($urandom), 8'($urandom),
                                   8'($urandom));
                end
            endcase
        end
        // sender waits here until the block has fully drained
        pending_items[450].wait_drain = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_if.valid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d items sent, %0d results checked in %0d cycles, %0d mismatches",
                 items_sent, results_checked, cycle_count, mismatches);
        $display("data-port reads %0d, writes %0d, row wraps %0d, nmi pulses %0d",
                 data_reads, data_writes, row_wraps, nmi_count);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
